FILE: rtl/crss_pkg.sv
// Shared types for the rectangle subtract-and-split block.
package crss_pkg;

	localparam int unsigned CoordW = 16;
	localparam int unsigned MaxPieces = 4;
	localparam int unsigned PieceIdxW = 2;

	// x in the lowest bits so a rect_t maps straight onto the result tdata
	typedef struct packed {
		logic signed [CoordW-1:0] height;
		logic signed [CoordW-1:0] width;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] x;
	} rect_t;

	// One classified input: pieces in emit order, index of the final one
	typedef struct packed {
		rect_t [MaxPieces-1:0]  rects;
		logic [PieceIdxW-1:0]   last_idx;
	} q_entry_t;

endpackage

FILE: rtl/crss_front.sv
// Front end: registers input transfers, forms the sums, classifies the gaps.
module crss_front import crss_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [127:0]  s_tdata,
	output logic          push_valid,
	input  logic          push_ready,
	output q_entry_t      push_data
);

	typedef struct packed {
		logic signed [CoordW-1:0] cut_max_y;
		logic signed [CoordW-1:0] cut_max_x;
		logic signed [CoordW-1:0] cut_min_y;
		logic signed [CoordW-1:0] cut_min_x;
		logic signed [CoordW-1:0] src_height;
		logic signed [CoordW-1:0] src_width;
		logic signed [CoordW-1:0] src_y;
		logic signed [CoordW-1:0] src_x;
	} in_t;

	typedef struct packed {
		in_t                      raw;
		logic signed [CoordW-1:0] xw;   // x + w
		logic signed [CoordW-1:0] yh;   // y + h
		logic signed [CoordW-1:0] xw1;  // x + w - 1
		logic signed [CoordW-1:0] yh1;  // y + h - 1
		logic signed [CoordW-1:0] mx1;  // max_x + 1
		logic signed [CoordW-1:0] my1;  // max_y + 1
		logic signed [CoordW-1:0] dy;   // max_y - y + 1
		logic signed [CoordW-1:0] bh;   // height below the cut
		logic signed [CoordW-1:0] lw;   // width left of the cut
		logic signed [CoordW-1:0] th;   // height above the cut
		logic signed [CoordW-1:0] rw;   // width right of the cut
		logic signed [CoordW-1:0] bh2;  // y + h - min_y
		logic signed [CoordW-1:0] mh;   // cut height
	} sums_t;

	localparam logic [3:0] GAP_NONE = 4'b0000;
	localparam logic [3:0] GAP_B    = 4'b0001;
	localparam logic [3:0] GAP_T    = 4'b0010;
	localparam logic [3:0] GAP_R    = 4'b0100;
	localparam logic [3:0] GAP_L    = 4'b1000;

	function automatic rect_t mk(input logic signed [CoordW-1:0] rx,
			input logic signed [CoordW-1:0] ry, input logic signed [CoordW-1:0] rw_i,
			input logic signed [CoordW-1:0] rh);
		rect_t r;
		r.x      = rx;
		r.y      = ry;
		r.width  = rw_i;
		r.height = rh;
		return r;
	endfunction

	logic  v1_q, v2_q;
	logic  adv1, adv2;
	in_t   in_s1;
	sums_t sum_s2;
	logic  miss;
	logic [3:0] gaps;
	q_entry_t e;

	assign adv2       = !v2_q || push_ready;
	assign adv1       = !v1_q || adv2;
	assign s_tready   = adv1;
	assign push_valid = v2_q;
	assign push_data  = e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (adv1) v1_q <= s_tvalid;
			if (adv2) v2_q <= v1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) in_s1 <= in_t'(s_tdata);
		if (adv2) begin
			sum_s2.raw <= in_s1;
			sum_s2.xw  <= in_s1.src_x + in_s1.src_width;
			sum_s2.yh  <= in_s1.src_y + in_s1.src_height;
			sum_s2.xw1 <= in_s1.src_x + in_s1.src_width - 16'sd1;
			sum_s2.yh1 <= in_s1.src_y + in_s1.src_height - 16'sd1;
			sum_s2.mx1 <= in_s1.cut_max_x + 16'sd1;
			sum_s2.my1 <= in_s1.cut_max_y + 16'sd1;
			sum_s2.dy  <= in_s1.cut_max_y - in_s1.src_y + 16'sd1;
			sum_s2.bh  <= in_s1.src_y + in_s1.src_height - in_s1.cut_max_y - 16'sd1;
			sum_s2.lw  <= in_s1.cut_min_x - in_s1.src_x;
			sum_s2.th  <= in_s1.cut_min_y - in_s1.src_y;
			sum_s2.rw  <= in_s1.src_x + in_s1.src_width - in_s1.cut_max_x - 16'sd1;
			sum_s2.bh2 <= in_s1.src_y + in_s1.src_height - in_s1.cut_min_y;
			sum_s2.mh  <= in_s1.cut_max_y - in_s1.cut_min_y + 16'sd1;
		end
	end

	always_comb begin
		rect_t pass_r, zero_r, src_top, bot_r;
		logic signed [CoordW-1:0] x, y, w, h, mnx, mny, mxx, mxy;
		x   = sum_s2.raw.src_x;
		y   = sum_s2.raw.src_y;
		w   = sum_s2.raw.src_width;
		h   = sum_s2.raw.src_height;
		mnx = sum_s2.raw.cut_min_x;
		mny = sum_s2.raw.cut_min_y;
		mxx = sum_s2.raw.cut_max_x;
		mxy = sum_s2.raw.cut_max_y;

		miss = (mnx > mxx) || (mny > mxy) || (mxx < x) || (mxy < y) ||
			(sum_s2.xw <= mnx) || (sum_s2.yh <= mny);
		gaps = {x < mnx, sum_s2.xw1 > mxx, y < mny, sum_s2.yh1 > mxy};

		pass_r  = mk(x, y, w, h);
		zero_r  = mk('0, '0, '0, '0);
		src_top = mk(x, y, w, sum_s2.th);
		bot_r   = mk(x, sum_s2.my1, w, sum_s2.bh);

		e.rects    = {MaxPieces{pass_r}};
		e.last_idx = '0;
		if (!miss) begin
			case (gaps)
				GAP_NONE: e.rects[0] = zero_r;
				GAP_B:    e.rects[0] = bot_r;
				GAP_T:    e.rects[0] = src_top;
				GAP_T | GAP_B: begin
					e.rects[0] = src_top;
					e.rects[1] = bot_r;
					e.last_idx = 2'd1;
				end
				GAP_R: e.rects[0] = mk(sum_s2.mx1, y, sum_s2.rw, h);
				GAP_R | GAP_B: begin
					e.rects[0] = mk(sum_s2.mx1, y, sum_s2.rw, sum_s2.dy);
					e.rects[1] = bot_r;
					e.last_idx = 2'd1;
				end
				GAP_R | GAP_T: begin
					e.rects[0] = src_top;
					e.rects[1] = mk(sum_s2.mx1, mny, sum_s2.rw, sum_s2.bh2);
					e.last_idx = 2'd1;
				end
				GAP_R | GAP_T | GAP_B: begin
					e.rects[0] = src_top;
					e.rects[1] = bot_r;
					e.rects[2] = mk(sum_s2.mx1, mny, sum_s2.rw, sum_s2.mh);
					e.last_idx = 2'd2;
				end
				GAP_L: e.rects[0] = mk(x, y, sum_s2.lw, h);
				GAP_L | GAP_B: begin
					e.rects[0] = mk(x, y, sum_s2.lw, sum_s2.dy);
					e.rects[1] = bot_r;
					e.last_idx = 2'd1;
				end
				GAP_L | GAP_T: begin
					e.rects[0] = src_top;
					e.rects[1] = mk(x, mny, sum_s2.lw, sum_s2.bh2);
					e.last_idx = 2'd1;
				end
				GAP_L | GAP_T | GAP_B: begin
					e.rects[0] = src_top;
					e.rects[1] = mk(x, mny, sum_s2.lw, sum_s2.mh);
					e.rects[2] = bot_r;
					e.last_idx = 2'd2;
				end
				GAP_L | GAP_R: begin
					e.rects[0] = mk(x, y, sum_s2.lw, h);
					e.rects[1] = mk(sum_s2.mx1, y, sum_s2.rw, h);
					e.last_idx = 2'd1;
				end
				GAP_L | GAP_R | GAP_B: begin
					e.rects[0] = bot_r;
					e.rects[1] = mk(x, y, sum_s2.lw, sum_s2.dy);
					e.rects[2] = mk(sum_s2.mx1, y, sum_s2.rw, sum_s2.dy);
					e.last_idx = 2'd2;
				end
				GAP_L | GAP_R | GAP_T: begin
					e.rects[0] = src_top;
					e.rects[1] = mk(x, mny, sum_s2.lw, sum_s2.bh2);
					e.rects[2] = mk(sum_s2.mx1, mny, sum_s2.rw, sum_s2.bh2);
					e.last_idx = 2'd2;
				end
				default: begin
					e.rects[0] = src_top;
					e.rects[1] = mk(x, mny, sum_s2.lw, sum_s2.mh);
					e.rects[2] = mk(sum_s2.mx1, mny, sum_s2.rw, sum_s2.mh);
					e.rects[3] = bot_r;
					e.last_idx = 2'd3;
				end
			endcase
		end
	end

endmodule

FILE: rtl/crss_fifo.sv
// Short queue of classified items between front end and emitter.
module crss_fifo import crss_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  q_entry_t push_data,
	output logic     pop_valid,
	input  logic     pop,
	output q_entry_t pop_data
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	q_entry_t         mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

endmodule

FILE: rtl/crss_back.sv
// Emitter: walks the pieces of the head entry into the output register.
module crss_back import crss_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pop_valid,
	output logic         pop,
	input  q_entry_t     pop_data,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,
	output logic         m_tuser,
	output logic         m_tlast
);

	logic [PieceIdxW-1:0] idx_q;
	logic                 out_valid_q, added_q, last_q;
	rect_t                rect_q;
	logic                 load, at_last;

	assign load    = pop_valid && (!out_valid_q || m_tready);
	assign at_last = idx_q == pop_data.last_idx;
	assign pop     = load && at_last;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = rect_q;
	assign m_tuser  = added_q;
	assign m_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_last ? '0 : idx_q + 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rect_q  <= pop_data.rects[idx_q];
			added_q <= idx_q != '0;
			last_q  <= at_last;
		end
	end

endmodule

FILE: rtl/clip_rect_subtract_split.sv
// Top level: clip rectangle minus obscurer, split into up to four pieces.
//
//  channel  dir  payload                                            items
//  s_*      in   tdata[127:0] = 8 x 16-bit input fields             1 per input
//  m_*      out  tdata[63:0] rect, tuser is_added, tlast last       1..4 per input
//
// An input reaches its first result through the input, sums, queue
// and output registers. The emitter puts out one rectangle a cycle
// while m_tready is high; at 1 to 4 per input it sets the sustained rate.
// A queue of QUEUE_DEPTH classified items lets the front end keep taking
// inputs while the emitter is stalled. arst_n clears all valid state.
module clip_rect_subtract_split import crss_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// src_x, src_y, src_width, src_height, cut_min_x, cut_min_y, cut_max_x, cut_max_y
	input  logic [127:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// out_x, out_y, out_width, out_height
	output logic [63:0]   m_tdata,
	// is_added
	output logic          m_tuser,
	output logic          m_tlast
);

	logic     push_valid, push_ready, pop_valid, pop;
	q_entry_t push_data, pop_data;

	crss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	crss_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_data   (pop_data)
	);

	crss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_data  (pop_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

`ifndef SYNTHESIS
	// input is only held off by a full queue
	a_ready_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> !push_ready)
		else $error("input stalled while queue had room");

	// a classified item blocked by the queue stays put
	a_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && !push_ready |=> push_valid && $stable(push_data))
		else $error("classified item lost while queue full");

	// an entry leaves the queue only with its final piece
	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop && pop_valid |=> m_tvalid && m_tlast)
		else $error("queue entry retired before its last piece");
`endif

endmodule
